// ----- sv/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int ST_W   = 2;
    localparam int SIZE_W = 5;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int S_DATA_W = ((POS_W + DATA_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W = ((DATA_WIDTH + SIZE_W + 1 + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_GET    = 3'd2,
        OP_SET    = 3'd3,
        OP_REMOVE = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_WRITE,
        ACT_INSERT,
        ACT_REMOVE
    } t_act;

    typedef struct packed {
        t_act             act;
        logic [CMP_W-1:0] pos;
        logic [CMP_W-1:0] count;
    } t_cell_cmd;

endpackage

// ----- sv/ils_cell.sv -----
// ----------------------------------------------------------------------------
// ils_cell
// One list entry: holds, loads the new word, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module ils_cell
    import ils_pkg::*;
(
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [CMP_W-1:0]      i_index,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_elem,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [CMP_W-1:0]      w_next_index;

    assign w_next_index = i_index + CMP_W'(1);

    always_comb begin
        n_data = r_data;
        case (i_cmd.act)
            ACT_WRITE: begin
                if (i_index == i_cmd.pos) n_data = i_elem;
            end
            ACT_INSERT: begin
                if (i_index == i_cmd.pos) begin
                    n_data = i_elem;
                end else if (i_index > i_cmd.pos && i_index <= i_cmd.count) begin
                    n_data = i_left;
                end
            end
            ACT_REMOVE: begin
                if (i_index >= i_cmd.pos && w_next_index < i_cmd.count) n_data = i_right;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- sv/indexed_list_store.sv -----
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list held in a row of shifting cells; append, insert, get, set,
// remove and clear, one operation per word.
// ----------------------------------------------------------------------------
//  channel  dir  fields (tdata low bit up | tuser)
//  s_axis   in   position, element_in     | opcode
//  m_axis   out  element_out, list_size, is_empty | status
//
//  one word per cycle unless a held result stalls input: each operation
//  finishes in the cycle it is accepted, all cells shifting together
//  the result lands in an output register in the cycle after acceptance
//  a held result stalls input only while m_axis_tready is low
//  reset clears the entry count and the output valid; cell contents are kept
// ----------------------------------------------------------------------------
module indexed_list_store
    import ils_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // position, element_in, zero pad
    input  logic [OP_W-1:0]     i_s_tuser,   // opcode
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // element_out, list_size, is_empty, zero pad
    output logic [ST_W-1:0]     o_m_tuser    // status
);

    logic [POS_W-1:0]      w_pos;
    logic [DATA_WIDTH-1:0] w_elem;
    logic [OP_W-1:0]       w_op;
    logic                  w_accept;

    logic [CMP_W-1:0]      w_pos_c;
    logic [CMP_W-1:0]      w_cnt_c;
    logic                  w_full;
    logic [DATA_WIDTH-1:0] w_cells [DEPTH];
    logic [DATA_WIDTH-1:0] w_rd;

    t_cell_cmd             w_cmd;
    t_status               w_status;
    logic [DATA_WIDTH-1:0] w_result;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_valid;
    t_status               r_status;
    logic [DATA_WIDTH-1:0] r_result;
    logic [CNT_W-1:0]      r_size;

    assign w_pos  = i_s_tdata[POS_W-1:0];
    assign w_elem = i_s_tdata[POS_W +: DATA_WIDTH];
    assign w_op   = i_s_tuser;

    assign o_s_tready = !r_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_pos_c = CMP_W'(w_pos);
    assign w_cnt_c = CMP_W'(r_count);
    assign w_full  = (w_cnt_c == CMP_W'(DEPTH));
    assign w_rd    = w_cells[w_pos_c[IDX_W-1:0]];

    always_comb begin
        w_cmd.act   = ACT_NONE;
        w_cmd.pos   = w_pos_c;
        w_cmd.count = w_cnt_c;
        w_status    = ST_OK;
        w_result    = '0;
        n_count     = r_count;
        case (w_op)
            OP_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.act = ACT_WRITE;
                    w_cmd.pos = w_cnt_c;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (w_pos_c > w_cnt_c) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.act = ACT_INSERT;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            OP_GET: begin
                if (w_pos_c >= w_cnt_c) w_status = ST_RANGE;
                else                    w_result = w_rd;
            end
            OP_SET: begin
                if (w_pos_c >= w_cnt_c) begin
                    w_status = ST_RANGE;
                end else begin
                    w_result  = w_rd;
                    w_cmd.act = ACT_WRITE;
                end
            end
            OP_REMOVE: begin
                if (w_pos_c >= w_cnt_c) begin
                    w_status = ST_RANGE;
                end else begin
                    w_result  = w_rd;
                    w_cmd.act = ACT_REMOVE;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_cmd.act = ACT_NONE;
            n_count   = r_count;
        end
    end

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (j == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cells[j-1];
        end

        if (j == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cells[j+1];
        end

        ils_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (CMP_W'(j)),
            .i_left  (w_left),
            .i_right (w_right),
            .i_elem  (w_elem),
            .o_data  (w_cells[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) r_valid <= 1'b1;
            else if (i_m_tready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_result <= w_result;
            r_size   <= n_count;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = M_DATA_W'({(r_size == '0),
                                   SIZE_W'(CMP_W'(r_size)),
                                   r_result});

endmodule

// ----- sim/tb_indexed_list_store.sv -----
// ----------------------------------------------------------------------------
// tb_indexed_list_store
// Self-checking bench for the indexed list store. Drives list operations on
// the input stream and checks every result word against a scoreboard that
// keeps its own copy of the list, across phases of input and output idling.
// ----------------------------------------------------------------------------
module tb_indexed_list_store;
    import ils_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 225;
    localparam int PAD_W          = S_DATA_W - POS_W - DATA_WIDTH;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        t_status               status;
        logic [DATA_WIDTH-1:0] element;
        logic [SIZE_W-1:0]     size;
        logic                  is_empty;
    } t_list_result;

    class list_scoreboard;
        logic [DATA_WIDTH-1:0] cells [DEPTH];
        int unsigned           fill;
        t_list_result          expected_q [$];
        int                    errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [DATA_WIDTH-1:0] val);
            t_list_result r;
            int           j;
            r.status  = ST_OK;
            r.element = '0;
            case (op)
                OP_APPEND: begin
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        cells[fill] = val;
                        fill++;
                    end
                end
                OP_INSERT: begin
                    if (pos > fill) begin
                        r.status = ST_RANGE;
                    end else if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        for (j = fill; j > pos; j--) cells[j] = cells[j-1];
                        cells[pos] = val;
                        fill++;
                    end
                end
                OP_GET: begin
                    if (pos >= fill) r.status = ST_RANGE;
                    else r.element = cells[pos];
                end
                OP_SET: begin
                    if (pos >= fill) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.element  = cells[pos];
                        cells[pos] = val;
                    end
                end
                OP_REMOVE: begin
                    if (pos >= fill) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.element = cells[pos];
                        for (j = pos; j + 1 < fill; j++) cells[j] = cells[j+1];
                        fill--;
                    end
                end
                OP_CLEAR: fill = 0;
                default: ;
            endcase
            r.size     = SIZE_W'(fill);
            r.is_empty = (fill == 0);
            expected_q.push_back(r);
        endfunction

        function void check_word(logic [M_DATA_W-1:0] data, logic [ST_W-1:0] st);
            t_list_result r;
            if (expected_q.size() == 0) begin
                $display("%0t: result word with none expected: status %0d data %h",
                         $time, st, data);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (st !== r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, st);
                errors++;
            end
            if (data[DATA_WIDTH-1:0] !== r.element) begin
                $display("%0t: element_out expected %h actual %h", $time, r.element,
                         data[DATA_WIDTH-1:0]);
                errors++;
            end
            if (data[DATA_WIDTH +: SIZE_W] !== r.size) begin
                $display("%0t: list_size expected %0d actual %0d", $time, r.size,
                         data[DATA_WIDTH +: SIZE_W]);
                errors++;
            end
            if (data[DATA_WIDTH+SIZE_W] !== r.is_empty) begin
                $display("%0t: is_empty expected %0b actual %0b", $time, r.is_empty,
                         data[DATA_WIDTH+SIZE_W]);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;   // position, element_in, zero pad
    logic [OP_W-1:0]     i_s_tuser  = '0;   // opcode
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;         // element_out, list_size, is_empty, zero pad
    logic [ST_W-1:0]     o_m_tuser;         // status

    list_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    bit growing        = 1'b1;

    indexed_list_store dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    always begin
        @(posedge i_clk);
        if (hold_req) begin
            i_m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_req = 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_word(o_m_tdata, o_m_tuser);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
        end
        $display("indexed_list_store: mismatch");
        $finish;
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [DATA_WIDTH-1:0] val);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{PAD_W{1'b0}}, val, pos};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_word(op, pos, val);
    endtask

    // mostly well-formed operations, drifting between growing and shrinking
    task automatic send_random_word();
        logic [OP_W-1:0]       op;
        logic [POS_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] val;
        int unsigned           n;
        int unsigned           roll;
        n    = sb.fill;
        roll = $urandom_range(99);
        if (n == DEPTH && $urandom_range(3) == 0) growing = 1'b0;
        else if (n == 0) growing = 1'b1;
        else if ($urandom_range(39) == 0) growing = !growing;
        if (roll < 2) op = OP_CLEAR;
        else if (roll < 4) op = ($urandom_range(1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
        else if (roll < 34) op = growing ? OP_APPEND : OP_REMOVE;
        else if (roll < 54) op = growing ? OP_INSERT : OP_REMOVE;
        else if (roll < 77) op = OP_GET;
        else op = OP_SET;
        if ($urandom_range(9) == 0) pos = POS_W'($urandom_range(31));
        else if (op == OP_INSERT) pos = POS_W'($urandom_range(n));
        else pos = (n > 0) ? POS_W'($urandom_range(n - 1)) : '0;
        case ($urandom_range(9))
            0: val = '0;
            1: val = '1;
            default: val = $urandom;
        endcase
        send_word(op, pos, val);
    endtask

    initial begin
        int ph;
        int k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: bad indexes, unused opcodes, clear
        send_word(OP_GET, 5'd0, 32'h0000_0000);
        send_word(OP_SET, 5'd0, 32'h1234_5678);
        send_word(OP_REMOVE, 5'd0, 32'h0);
        send_word(OP_INSERT, 5'd1, 32'hDEAD_BEEF);
        send_word(OP_SPARE_LO, 5'd31, 32'hFFFF_FFFF);
        send_word(OP_SPARE_HI, 5'd0, 32'h0);
        send_word(OP_CLEAR, 5'd16, 32'h0);
        // fill to capacity, inserting at the head and at the tail
        for (k = 0; k < DEPTH; k++) begin
            case (k % 3)
                0: send_word(OP_APPEND, 5'd0,
                             (k == 0) ? 32'hFFFF_FFFF : 32'h8000_0000 + k);
                1: send_word(OP_INSERT, 5'd0, (k == 1) ? 32'h0 : 32'h5A5A_0000 + k);
                default: send_word(OP_INSERT, POS_W'(sb.fill), 32'hA5A5_0000 + k);
            endcase
        end
        // full list, range beating full, edge reads and removals
        send_word(OP_APPEND, 5'd0, 32'h1111_1111);
        send_word(OP_INSERT, 5'd16, 32'h2222_2222);
        send_word(OP_INSERT, 5'd17, 32'h3333_3333);
        send_word(OP_SET, 5'd15, 32'hFFFF_FFFF);
        send_word(OP_GET, 5'd31, 32'h0);
        send_word(OP_REMOVE, 5'd15, 32'h0);
        send_word(OP_REMOVE, 5'd0, 32'h0);
        send_word(OP_CLEAR, 5'd0, 32'h0);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (k = 0; k < RANDOM_WORDS; k++) begin
                if (ph == 0 && k == 40) hold_req = 1'b1;
                send_random_word();
            end
        end

        i_s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("indexed_list_store: match");
        end else begin
            $display("indexed_list_store: mismatch");
        end
        $finish;
    end

endmodule

// ----- indexed_list_store.f -----
sv/ils_pkg.sv
sv/ils_cell.sv
sv/indexed_list_store.sv
sim/tb_indexed_list_store.sv
